// ----- design/sha256_message_hasher_defines.svh -----
// Assertion macros used by the hasher design file.
// Each check is clocked on clk and is held off while arst_n is low.
`ifndef SHA256_MESSAGE_HASHER_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define SHAH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SHAH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/shah_pkg.sv -----
`default_nettype none

package shah_pkg;

	localparam int WORD_W    = 32;
	localparam int BUF_WORDS = 16;
	localparam int BUF_AW    = $clog2(BUF_WORDS);
	localparam int ROUNDS    = 64;
	localparam int DIG_WORDS = 8;
	localparam int COUNT_W   = 61;

	typedef logic [WORD_W-1:0] word_t;

	// One message transaction
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} msg_item_t;

	// One digest transaction
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        digest_done;
	} dig_item_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam word_t ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t INIT_HASH [DIG_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// Round functions
	function automatic word_t bsig0(word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t bsig1(word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	// Message schedule functions
	function automatic word_t ssig0(word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic word_t ssig1(word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

	function automatic word_t choose(word_t e, word_t f, word_t g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic word_t major(word_t a, word_t b, word_t c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

`default_nettype wire

// ----- design/shah_ram.sv -----
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module shah_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- design/sha256_message_hasher.sv -----
`default_nettype none
`include "sha256_message_hasher_defines.svh"

// SHA-256 hasher with a byte-wide message port and a word-wide digest port.
// A transaction carrying a byte, with no end mark, is taken without a stall
// unless it completes a 64-byte block; message bytes are packed four to a
// word into a 16-word block RAM. A full block holds the message port stalled
// through a RAM read setup state, a load state, 64 rounds at one round per
// cycle, and a fold of the result into the chaining words. The end mark adds
// one padding block, or two when fewer than nine bytes of room remain in the
// current block. Padding is formed on the fly as the block is read, so the
// RAM never needs clearing. The digest goes to its own register bank and
// leaves as eight transactions while the next message streams in; a second
// digest waits in the fold cycle until the previous one has fully drained.
module sha256_message_hasher import shah_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      msg_valid,
	output logic      msg_stall,
	input  msg_item_t msg,
	output logic      dig_valid,
	input  logic      dig_stall,
	output dig_item_t dig
);

	typedef enum logic [2:0] {ST_IDLE, ST_START, ST_LOAD, ST_ROUND, ST_FEED} state_t;
	typedef enum logic [1:0] {MODE_NORMAL, MODE_PAD1, MODE_PAD2} mode_t;

	state_t               state_q;
	mode_t                mode_q;
	logic                 last_q;
	logic [5:0]           round_q;
	logic [COUNT_W-1:0]   count_q;
	word_t                chain_q [DIG_WORDS];
	logic                 dig_busy_q;
	logic [2:0]           dig_idx_q;

	word_t                part_q;
	word_t                work_q [DIG_WORDS];
	word_t                sched_q [BUF_WORDS];
	word_t                wk_q;
	word_t                dig_q [DIG_WORDS];

	logic                 msg_take;
	logic [1:0]           lane;
	logic                 block_full;
	logic                 pad_two;
	logic                 final_blk;
	logic [63:0]          bit_len;
	word_t                tail_word;
	word_t                blk_word;
	logic [BUF_AW-1:0]    sidx;
	logic [5:0]           sched_j;
	logic                 use_blk;
	word_t                new_w;
	word_t                wk_next;
	word_t                t1;
	word_t                t2;
	word_t                feed_sum [DIG_WORDS];

	logic                 ram_wr_en;
	logic [BUF_AW-1:0]    ram_wr_addr;
	word_t                ram_wr_data;
	logic [BUF_AW-1:0]    ram_rd_addr;
	word_t                ram_rd_data;

	// Handshake
	assign msg_stall = (state_q != ST_IDLE);
	assign msg_take  = msg_valid && !msg_stall;

	assign dig_valid       = dig_busy_q;
	assign dig.digest_word = dig_q[dig_idx_q];
	assign dig.word_index  = dig_idx_q;
	assign dig.digest_done = (dig_idx_q == 3'd7);

	// Fill position and padding decisions
	assign lane       = count_q[1:0];
	assign block_full = msg_take && msg.has_byte && (count_q[5:0] == 6'd63);
	assign pad_two    = (count_q[5:3] == 3'b111);
	assign final_blk  = (mode_q == MODE_PAD2) || ((mode_q == MODE_PAD1) && !pad_two);
	assign bit_len    = {count_q, 3'b000};

	// Complete words go to the block RAM
	assign ram_wr_en   = msg_take && msg.has_byte && (lane == 2'd3);
	assign ram_wr_addr = count_q[5:2];
	assign ram_wr_data = {part_q[31:8], msg.data_byte};

	// Read one word ahead of the schedule
	always_comb begin
		unique case (state_q)
			ST_LOAD:  ram_rd_addr = BUF_AW'(1);
			ST_ROUND: ram_rd_addr = BUF_AW'(round_q + 6'd2);
			default:  ram_rd_addr = '0;
		endcase
	end

	shah_ram #(
		.WIDTH(WORD_W),
		.DEPTH(BUF_WORDS)
	) u_buf (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Partial word with the 0x80 marker after the held bytes
	always_comb begin
		unique case (lane)
			2'd0:    tail_word = {PAD_BYTE, 24'h0};
			2'd1:    tail_word = {part_q[31:24], PAD_BYTE, 16'h0};
			2'd2:    tail_word = {part_q[31:16], PAD_BYTE, 8'h0};
			default: tail_word = {part_q[31:8], PAD_BYTE};
		endcase
	end

	// Schedule index of the word formed this cycle
	assign sched_j = (state_q == ST_LOAD) ? 6'd0 : 6'(round_q + 6'd1);
	assign sidx    = sched_j[BUF_AW-1:0];
	assign use_blk = (state_q == ST_LOAD) || (round_q < 6'd15);

	// Block word: stored data, padding, or length
	always_comb begin
		unique case (mode_q)
			MODE_PAD1: begin
				priority if (sidx < count_q[5:2]) begin
					blk_word = ram_rd_data;
				end else if (sidx == count_q[5:2]) begin
					blk_word = tail_word;
				end else if (!pad_two && (sidx == 4'd14)) begin
					blk_word = bit_len[63:32];
				end else if (!pad_two && (sidx == 4'd15)) begin
					blk_word = bit_len[31:0];
				end else begin
					blk_word = '0;
				end
			end
			MODE_PAD2: begin
				priority if (sidx == 4'd14) begin
					blk_word = bit_len[63:32];
				end else if (sidx == 4'd15) begin
					blk_word = bit_len[31:0];
				end else begin
					blk_word = '0;
				end
			end
			default: blk_word = ram_rd_data;
		endcase
	end

	// Message schedule, one word a cycle, with the round constant folded in
	assign new_w   = use_blk ? blk_word
		: sched_q[0] + ssig0(sched_q[1]) + sched_q[9] + ssig1(sched_q[14]);
	assign wk_next = new_w + ROUND_K[sched_j];

	// Round datapath
	assign t1 = work_q[7] + bsig1(work_q[4]) + choose(work_q[4], work_q[5], work_q[6]) + wk_q;
	assign t2 = bsig0(work_q[0]) + major(work_q[0], work_q[1], work_q[2]);

	always_comb begin
		for (int i = 0; i < DIG_WORDS; i++) begin
			feed_sum[i] = chain_q[i] + work_q[i];
		end
	end

	// Control state, chaining words and digest drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MODE_NORMAL;
			last_q     <= 1'b0;
			round_q    <= '0;
			count_q    <= '0;
			chain_q    <= INIT_HASH;
			dig_busy_q <= 1'b0;
			dig_idx_q  <= '0;
		end else begin
			if (dig_busy_q && !dig_stall) begin
				if (dig_idx_q == 3'd7) begin
					dig_busy_q <= 1'b0;
					dig_idx_q  <= '0;
				end else begin
					dig_idx_q <= dig_idx_q + 3'd1;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (msg_take) begin
						if (msg.has_byte) begin
							count_q <= count_q + COUNT_W'(1);
						end
						if (block_full) begin
							mode_q  <= MODE_NORMAL;
							last_q  <= msg.end_of_message;
							state_q <= ST_START;
						end else if (msg.end_of_message) begin
							mode_q  <= MODE_PAD1;
							last_q  <= 1'b0;
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					round_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						state_q <= ST_FEED;
					end
				end
				ST_FEED: begin
					if (final_blk) begin
						// hold here until the previous digest has drained
						if (!dig_busy_q) begin
							dig_busy_q <= 1'b1;
							dig_idx_q  <= '0;
							chain_q    <= INIT_HASH;
							count_q    <= '0;
							mode_q     <= MODE_NORMAL;
							state_q    <= ST_IDLE;
						end
					end else begin
						chain_q <= feed_sum;
						if ((mode_q == MODE_NORMAL) && last_q) begin
							mode_q  <= MODE_PAD1;
							last_q  <= 1'b0;
							state_q <= ST_START;
						end else if (mode_q == MODE_PAD1) begin
							mode_q  <= MODE_PAD2;
							state_q <= ST_START;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (msg_take && msg.has_byte) begin
			unique case (lane)
				2'd0:    part_q[31:24] <= msg.data_byte;
				2'd1:    part_q[23:16] <= msg.data_byte;
				2'd2:    part_q[15:8]  <= msg.data_byte;
				default: part_q[7:0]   <= msg.data_byte;
			endcase
		end

		if (state_q == ST_LOAD) begin
			work_q <= chain_q;
		end else if (state_q == ST_ROUND) begin
			work_q[0] <= t1 + t2;
			work_q[1] <= work_q[0];
			work_q[2] <= work_q[1];
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3] + t1;
			work_q[5] <= work_q[4];
			work_q[6] <= work_q[5];
			work_q[7] <= work_q[6];
		end

		if ((state_q == ST_LOAD) || (state_q == ST_ROUND)) begin
			for (int i = 0; i < BUF_WORDS - 1; i++) begin
				sched_q[i] <= sched_q[i+1];
			end
			sched_q[BUF_WORDS-1] <= new_w;
			wk_q                 <= wk_next;
		end

		if ((state_q == ST_FEED) && final_blk && !dig_busy_q) begin
			dig_q <= feed_sum;
		end
	end

	// Checks
	`SHAH_ASSERT_NEXT(a_round_end, (state_q == ST_ROUND) && (round_q == 6'd63),
		state_q == ST_FEED, "compression did not end after the last round")
	`SHAH_ASSERT_NEXT(a_block_start,
		msg_valid && !msg_stall && msg.has_byte && (count_q[5:0] == 6'd63),
		(state_q == ST_START) && (mode_q == MODE_NORMAL), "full block not compressed")
	`SHAH_ASSERT_NEXT(a_dig_hold, (state_q == ST_FEED) && final_blk && dig_busy_q,
		state_q == ST_FEED, "digest overwritten before drained")
	`SHAH_ASSERT_NEXT(a_dig_end, dig_valid && dig.digest_done && !dig_stall,
		!dig_valid, "digest output ran past the last word")

endmodule

`default_nettype wire
